// ===== rtl/core/sbb_pkg.sv =====
`timescale 1ns / 1ps

package sbb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int RESET_DIM      = 1024;
    localparam int DIM_MIN        = 3;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int LINE_W = 3 * PIX_W;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // command handed from the sequencer to the column stage
    typedef struct packed {
        logic             do_update;
        logic             has_out;
        logic             sel_raw;
        logic             frame_end;
        logic [PIX_W-1:0] h;
        logic [PIX_W-1:0] raw;
    } sbb_cmd_t;

endpackage

// ===== rtl/core/sbb_ifs.sv =====
`timescale 1ns / 1ps

interface sbb_in_if;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [sbb_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output action, output pixel_in, input ready);
    modport sink (input valid, input action, input pixel_in, output ready);
endinterface

interface sbb_out_if;
    logic                     valid;
    logic                     ready;
    logic [sbb_pkg::PIX_W-1:0] pixel_out;
    logic                     frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== rtl/core/sbb_ram.sv =====
`timescale 1ns / 1ps

module sbb_ram #(
    parameter int WIDTH = sbb_pkg::LINE_W,
    parameter int DEPTH = sbb_pkg::MAX_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sbb_ctrl.sv =====
`timescale 1ns / 1ps

module sbb_ctrl #(
    parameter int MAX_WIDTH  = sbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbb_pkg::MAX_HEIGHT_DEF,
    localparam int CW        = $clog2(MAX_WIDTH + 1),
    localparam int RW        = $clog2(MAX_HEIGHT + 1),
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CW-1:0]     frame_width,
    input  logic [RW-1:0]     frame_height,
    input  logic              restart,
    input  logic              pipe_ready,
    sbb_in_if.sink            in_ch,
    output logic              cmd_valid,
    output sbb_pkg::sbb_cmd_t cmd,
    output logic [AW-1:0]     rd_addr
);

    logic [CW-1:0]                col_reg, col_next;
    logic [RW-1:0]                row_reg, row_next;
    logic [sbb_pkg::PIX_W-1:0]    left_reg, left_next;
    logic [sbb_pkg::PIX_W-1:0]    centre_reg, centre_next;

    logic                         accept;
    logic                         draining;
    logic [CW-1:0]                wm1;
    logic [CW-1:0]                pc;
    logic [RW-1:0]                pr;
    logic [CW-1:0]                col_inc;
    logic [sbb_pkg::PIX_W+1:0]    hsum;
    logic [sbb_pkg::PIX_W-1:0]    hval;

    assign in_ch.ready = pipe_ready;
    assign accept      = in_ch.valid && pipe_ready;
    assign draining    = row_reg >= frame_height;
    assign wm1         = frame_width - CW'(1);
    assign col_inc     = col_reg + CW'(1);
    assign pc          = (col_reg == '0) ? wm1 : col_reg - CW'(1);
    assign pr          = (col_reg == '0) ? row_reg - RW'(1) : row_reg;
    assign hsum        = {2'b00, left_reg} + {1'b0, centre_reg, 1'b0}
                       + {2'b00, in_ch.pixel_in};

    always_comb
    begin
        if (pc == '0 || pc == wm1)
        begin
            hval = centre_reg;
        end
        else
        begin
            hval = hsum[sbb_pkg::PIX_W+1:2];
        end
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        centre_next = centre_reg;
        cmd_valid   = 1'b0;
        cmd         = '0;
        rd_addr     = pc[AW-1:0];
        if (restart)
        begin
            col_next    = '0;
            row_next    = '0;
            left_next   = '0;
            centre_next = '0;
        end
        else if (accept)
        begin
            if (in_ch.action == sbb_pkg::ACT_PIXEL)
            begin
                if (!draining)
                begin
                    if (row_reg != '0 || col_reg != '0)
                    begin
                        cmd_valid     = 1'b1;
                        cmd.do_update = 1'b1;
                        cmd.has_out   = (pr != '0);
                        cmd.sel_raw   = (pr == RW'(1));
                        cmd.h         = hval;
                        cmd.raw       = centre_reg;
                    end
                    left_next   = centre_reg;
                    centre_next = in_ch.pixel_in;
                    if (col_inc == frame_width)
                    begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
            end
            else if (draining)
            begin
                cmd_valid   = 1'b1;
                cmd.has_out = 1'b1;
                if (col_reg == '0)
                begin
                    // last pixel of the frame sits in a border column
                    cmd.do_update = 1'b1;
                    cmd.h         = centre_reg;
                    cmd.raw       = centre_reg;
                    rd_addr       = wm1[AW-1:0];
                    col_next      = CW'(1);
                end
                else
                begin
                    cmd.sel_raw = 1'b1;
                    rd_addr     = pc[AW-1:0];
                    if (col_reg == frame_width)
                    begin
                        cmd.frame_end = 1'b1;
                        col_next      = '0;
                        row_next      = '0;
                        left_next     = '0;
                        centre_next   = '0;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            centre_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            centre_reg <= centre_next;
        end
    end

endmodule

// ===== rtl/core/sbb_vpass.sv =====
`timescale 1ns / 1ps

module sbb_vpass #(
    parameter int MAX_WIDTH = sbb_pkg::MAX_WIDTH_DEF,
    localparam int AW       = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  sbb_pkg::sbb_cmd_t           cmd,
    input  logic [AW-1:0]               cmd_addr,
    input  logic [sbb_pkg::LINE_W-1:0]  rd_data,
    output logic                        pipe_ready,
    output logic                        we,
    output logic [AW-1:0]               waddr,
    output logic [sbb_pkg::LINE_W-1:0]  wdata,
    sbb_out_if.source                   out_ch
);

    localparam int P = sbb_pkg::PIX_W;

    logic              s1_valid_reg, s1_valid_next;
    sbb_pkg::sbb_cmd_t s1_cmd_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              out_valid_reg, out_valid_next;
    logic [P-1:0]      out_pix_reg, out_pix_next;
    logic              out_end_reg, out_end_next;

    logic              advance;
    logic              move;
    logic [P-1:0]      up, mid, old_raw;
    logic [P+1:0]      vsum;

    // line word: upper blur, middle blur, raw pixel
    assign up      = rd_data[3*P-1:2*P];
    assign mid     = rd_data[2*P-1:P];
    assign old_raw = rd_data[P-1:0];
    assign vsum    = {2'b00, up} + {1'b0, mid, 1'b0} + {2'b00, s1_cmd_reg.h};

    assign advance    = !out_valid_reg || out_ch.ready;
    assign move       = s1_valid_reg && advance;
    assign pipe_ready = !s1_valid_reg || advance;

    assign we    = move && s1_cmd_reg.do_update;
    assign waddr = s1_addr_reg;
    assign wdata = {mid, s1_cmd_reg.h, s1_cmd_reg.raw};

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_end_next   = out_end_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            s1_valid_next = 1'b0;
            if (s1_cmd_reg.has_out)
            begin
                out_valid_next = 1'b1;
                out_pix_next   = s1_cmd_reg.sel_raw ? old_raw : vsum[P+1:2];
                out_end_next   = s1_cmd_reg.frame_end;
            end
        end
        if (cmd_valid)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            s1_cmd_reg  <= cmd;
            s1_addr_reg <= cmd_addr;
        end
        out_pix_reg <= out_pix_next;
        out_end_reg <= out_end_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel_out = out_pix_reg;
    assign out_ch.frame_end = out_end_reg;

endmodule

// ===== rtl/core/separable_binomial_blur_3x3_core.sv =====
`timescale 1ns / 1ps
// Pipeline: command and RAM read are registered, then the result. Throughput: one beat
// per cycle unless the output stalls; each command reads one column of the single
// line-store RAM (upper blur, middle blur, raw pixel); all but raw drains write back.
// Reset: counters, pixel pipe and handshake clear at once; frame size returns
// to 1024 (or the maximum); the line store is not cleared and needs no pass.

module separable_binomial_blur_3x3_core #(
    parameter int MAX_WIDTH  = sbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbb_pkg::APB_AW-1:0]  paddr,
    input  logic [sbb_pkg::APB_DW-1:0]  pwdata,
    output logic [sbb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    sbb_in_if.sink                      in_ch,
    sbb_out_if.source                   out_ch
);

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RST_W = (MAX_WIDTH < sbb_pkg::RESET_DIM) ? MAX_WIDTH : sbb_pkg::RESET_DIM;
    localparam int RST_H = (MAX_HEIGHT < sbb_pkg::RESET_DIM) ? MAX_HEIGHT
                                                             : sbb_pkg::RESET_DIM;

    logic [CW-1:0]              width_reg, width_next;
    logic [RW-1:0]              height_reg, height_next;
    logic                       cfg_wr;
    logic [sbb_pkg::DIM_W-1:0]  wr_val;
    int                         w_clamp;
    int                         h_clamp;

    logic                       pipe_ready;
    logic                       cmd_valid;
    sbb_pkg::sbb_cmd_t          cmd;
    logic [AW-1:0]              rd_addr;
    logic [sbb_pkg::LINE_W-1:0] rd_data;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [sbb_pkg::LINE_W-1:0] wdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_val = pwdata[sbb_pkg::DIM_W-1:0];

    always_comb
    begin
        w_clamp = (int'(wr_val) < sbb_pkg::DIM_MIN) ? sbb_pkg::DIM_MIN
                : (int'(wr_val) > MAX_WIDTH) ? MAX_WIDTH : int'(wr_val);
        h_clamp = (int'(wr_val) < sbb_pkg::DIM_MIN) ? sbb_pkg::DIM_MIN
                : (int'(wr_val) > MAX_HEIGHT) ? MAX_HEIGHT : int'(wr_val);
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                sbb_pkg::REG_FRAME_WIDTH:  width_next  = CW'(w_clamp);
                sbb_pkg::REG_FRAME_HEIGHT: height_next = RW'(h_clamp);
                default:                   width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sbb_pkg::REG_FRAME_WIDTH:  prdata = sbb_pkg::APB_DW'(width_reg);
            sbb_pkg::REG_FRAME_HEIGHT: prdata = sbb_pkg::APB_DW'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(RST_W);
            height_reg <= RW'(RST_H);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    sbb_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .restart      (cfg_wr),
        .pipe_ready   (pipe_ready),
        .in_ch        (in_ch),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .rd_addr      (rd_addr)
    );

    sbb_ram #(
        .WIDTH (sbb_pkg::LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd_valid),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    sbb_vpass #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_vpass (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_addr   (rd_addr),
        .rd_data    (rd_data),
        .pipe_ready (pipe_ready),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .out_ch     (out_ch)
    );

`ifndef SYNTHESIS
    // read and write-back of one column never land in the same cycle
    a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (we && cmd_valid) |-> (waddr != rd_addr))
        else $error("line store read and write hit the same column");

    // input stalls only behind a result that is itself stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
        else $error("input stalled with output side free");

    // a command without write-back is a drain read of the raw row
    a_drain_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd.do_update) |-> (cmd.has_out && cmd.sel_raw))
        else $error("malformed drain command");

    // frame end comes only from a drain read
    a_end_src: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.frame_end) |-> (in_ch.action == sbb_pkg::ACT_DRAIN))
        else $error("frame end raised by a pixel beat");
`endif

endmodule
